/* rtl/core/jsu_pkg.sv */
// jsu_pkg: shared types, codes and utf-8 helpers of the json string unescaper
// no dependencies
`default_nettype none

package jsu_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;

	localparam logic [15:0] SURR_HI_MIN = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;

	localparam logic [20:0] LIM_1B = 21'h00080;
	localparam logic [20:0] LIM_2B = 21'h00800;
	localparam logic [20:0] LIM_3B = 21'h10000;

	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT  = 8'h80;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		TAIL_NONE = 2'd0,
		TAIL_BYTE = 2'd1,
		TAIL_END  = 2'd2,
		TAIL_ERR  = 2'd3
	} tail_t;

	// one input byte's worth of results: up to two encodes then a tail result
	typedef struct packed {
		logic        enc0_en;
		logic [20:0] enc0_cp;
		logic        enc1_en;
		logic [15:0] enc1_cp;
		tail_t       tail;
		logic [7:0]  tail_byte;
	} cmd_t;

	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		logic [2:0] n;
		if (cp < LIM_1B) begin
			n = 3'd1;
		end else if (cp < LIM_2B) begin
			n = 3'd2;
		end else if (cp < LIM_3B) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
			input logic [2:0] k);
		logic [7:0] b;
		b = 8'h00;
		unique case (len)
			3'd1: b = cp[7:0];
			3'd2: b = (k == 3'd0) ? (LEAD2 | {3'b000, cp[10:6]}) : (CONT | {2'b00, cp[5:0]});
			3'd3: begin
				unique case (k)
					3'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
					3'd1:    b = CONT | {2'b00, cp[11:6]};
					default: b = CONT | {2'b00, cp[5:0]};
				endcase
			end
			default: begin
				unique case (k)
					3'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
					3'd1:    b = CONT | {2'b00, cp[17:12]};
					3'd2:    b = CONT | {2'b00, cp[11:6]};
					default: b = CONT | {2'b00, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/jsu_in_if.sv */
// jsu_in_if: raw text byte channel into the unescaper
// no dependencies
`default_nettype none

interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/jsu_out_if.sv */
// jsu_out_if: decoded result channel out of the unescaper
// no dependencies
`default_nettype none

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       last;

	modport source (output valid, output out_byte, output kind, output last, input ready);
	modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/jsu_front.sv */
// jsu_front: parser state machine, turns each accepted byte into at most one command
// depends on jsu_pkg and jsu_in_if
`default_nettype none

module jsu_front
	import jsu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	jsu_in_if.sink    in,
	input  wire logic fifo_full,
	output logic      push,
	output cmd_t      cmd
);

	localparam logic [3:0] P_WAIT  = 4'd0;
	localparam logic [3:0] P_BODY  = 4'd1;
	localparam logic [3:0] P_ESC   = 4'd2;
	localparam logic [3:0] P_HEX0  = 4'd3;
	localparam logic [3:0] P_HEX1  = 4'd4;
	localparam logic [3:0] P_HEX2  = 4'd5;
	localparam logic [3:0] P_HEX3  = 4'd6;
	localparam logic [3:0] P_PBS   = 4'd7;
	localparam logic [3:0] P_PU    = 4'd8;
	localparam logic [3:0] P_PHEX0 = 4'd9;
	localparam logic [3:0] P_PHEX1 = 4'd10;
	localparam logic [3:0] P_PHEX2 = 4'd11;
	localparam logic [3:0] P_PHEX3 = 4'd12;

	logic [3:0]  phase_q, phase_d;
	logic [15:0] hex_q, hex_d;
	logic [15:0] pend_q, pend_d;

	logic [7:0]  c;
	logic        accept;
	logic        hv_ok;
	logic [3:0]  hv;
	logic [15:0] hex_new;
	logic        new_is_hi, new_is_lo;

	tail_t       b_tail, e_tail;
	logic [7:0]  b_byte, e_byte;
	logic [3:0]  b_phase, e_phase;
	logic        b_wait, e_wait, e_hexclr;
	logic        go_wait;
	logic        has_res;

	assign c        = in.in_byte;
	assign in.ready = !fifo_full;
	assign accept   = in.valid && in.ready;

	always_comb begin
		hv_ok = 1'b1;
		hv    = 4'd0;
		priority if (c >= 8'h30 && c <= 8'h39) begin
			hv = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			hv = c[3:0] + 4'd9;
		end else begin
			hv_ok = 1'b0;
		end
	end

	assign hex_new   = {hex_q[11:0], hv};
	assign new_is_hi = (hex_new >= SURR_HI_MIN) && (hex_new <= SURR_HI_MAX);
	assign new_is_lo = (hex_new >= SURR_LO_MIN) && (hex_new <= SURR_LO_MAX);

	// byte seen as part of the string body
	always_comb begin
		b_tail  = TAIL_NONE;
		b_byte  = 8'h00;
		b_phase = P_BODY;
		b_wait  = 1'b0;
		priority if (c == CH_QUOTE) begin
			b_tail = TAIL_END;
			b_wait = 1'b1;
		end else if (c == CH_BSLASH) begin
			b_phase = P_ESC;
		end else if (c == CH_NUL) begin
			b_tail = TAIL_ERR;
			b_wait = 1'b1;
		end else begin
			b_tail = TAIL_BYTE;
			b_byte = c;
		end
	end

	// byte seen right after a backslash
	always_comb begin
		e_tail   = TAIL_BYTE;
		e_byte   = 8'h00;
		e_phase  = P_BODY;
		e_wait   = 1'b0;
		e_hexclr = 1'b0;
		unique case (c)
			CH_QUOTE:  e_byte = CH_QUOTE;
			CH_BSLASH: e_byte = CH_BSLASH;
			CH_SLASH:  e_byte = CH_SLASH;
			CH_B:      e_byte = CTL_BS;
			CH_F:      e_byte = CTL_FF;
			CH_N:      e_byte = CTL_LF;
			CH_R:      e_byte = CTL_CR;
			CH_T:      e_byte = CTL_HT;
			CH_U: begin
				e_tail   = TAIL_NONE;
				e_phase  = P_HEX0;
				e_hexclr = 1'b1;
			end
			default: begin
				e_tail = TAIL_ERR;
				e_wait = 1'b1;
			end
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		hex_d   = hex_q;
		pend_d  = pend_q;
		cmd     = '0;
		go_wait = 1'b0;
		unique case (phase_q)
			P_BODY: begin
				cmd.tail      = b_tail;
				cmd.tail_byte = b_byte;
				phase_d       = b_phase;
				go_wait       = b_wait;
			end
			P_ESC: begin
				cmd.tail      = e_tail;
				cmd.tail_byte = e_byte;
				phase_d       = e_phase;
				go_wait       = e_wait;
				if (e_hexclr) begin
					hex_d = '0;
				end
			end
			P_HEX0, P_HEX1, P_HEX2: begin
				if (!hv_ok) begin
					cmd.tail = TAIL_ERR;
					go_wait  = 1'b1;
				end else begin
					hex_d   = hex_new;
					phase_d = phase_q + 4'd1;
				end
			end
			P_HEX3: begin
				if (!hv_ok) begin
					cmd.tail = TAIL_ERR;
					go_wait  = 1'b1;
				end else begin
					hex_d = hex_new;
					if (new_is_hi) begin
						pend_d  = hex_new;
						phase_d = P_PBS;
					end else begin
						cmd.enc0_en = 1'b1;
						cmd.enc0_cp = {5'b00000, hex_new};
						phase_d     = P_BODY;
					end
				end
			end
			P_PBS: begin
				if (c == CH_BSLASH) begin
					phase_d = P_PU;
				end else begin
					cmd.enc0_en   = 1'b1;
					cmd.enc0_cp   = {5'b00000, pend_q};
					cmd.tail      = b_tail;
					cmd.tail_byte = b_byte;
					phase_d       = b_phase;
					go_wait       = b_wait;
				end
			end
			P_PU: begin
				if (c == CH_U) begin
					hex_d   = '0;
					phase_d = P_PHEX0;
				end else begin
					cmd.enc0_en   = 1'b1;
					cmd.enc0_cp   = {5'b00000, pend_q};
					cmd.tail      = e_tail;
					cmd.tail_byte = e_byte;
					phase_d       = e_phase;
					go_wait       = e_wait;
					if (e_hexclr) begin
						hex_d = '0;
					end
				end
			end
			P_PHEX0, P_PHEX1, P_PHEX2: begin
				if (!hv_ok) begin
					cmd.enc0_en = 1'b1;
					cmd.enc0_cp = {5'b00000, pend_q};
					cmd.tail    = TAIL_ERR;
					go_wait     = 1'b1;
				end else begin
					hex_d   = hex_new;
					phase_d = phase_q + 4'd1;
				end
			end
			P_PHEX3: begin
				if (!hv_ok) begin
					cmd.enc0_en = 1'b1;
					cmd.enc0_cp = {5'b00000, pend_q};
					cmd.tail    = TAIL_ERR;
					go_wait     = 1'b1;
				end else begin
					hex_d       = hex_new;
					cmd.enc0_en = 1'b1;
					pend_d      = '0;
					if (new_is_lo) begin
						cmd.enc0_cp = SUPP_BASE + {1'b0, pend_q[9:0], hex_new[9:0]};
						phase_d     = P_BODY;
					end else begin
						cmd.enc0_cp = {5'b00000, pend_q};
						if (new_is_hi) begin
							pend_d  = hex_new;
							phase_d = P_PBS;
						end else begin
							cmd.enc1_en = 1'b1;
							cmd.enc1_cp = hex_new;
							phase_d     = P_BODY;
						end
					end
				end
			end
			default: begin
				if (c == CH_QUOTE) begin
					hex_d   = '0;
					pend_d  = '0;
					phase_d = P_BODY;
				end else begin
					cmd.tail = TAIL_ERR;
					go_wait  = 1'b1;
				end
			end
		endcase
		if (go_wait) begin
			phase_d = P_WAIT;
			hex_d   = '0;
			pend_d  = '0;
		end
	end

	assign has_res = cmd.enc0_en || cmd.enc1_en || (cmd.tail != TAIL_NONE);
	assign push    = accept && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_WAIT;
			hex_q   <= '0;
			pend_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			hex_q   <= hex_d;
			pend_q  <= pend_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/jsu_cmd_fifo.sv */
// jsu_cmd_fifo: short command queue between the parser and the result expander
// depends on jsu_pkg
`default_nettype none

module jsu_cmd_fifo
	import jsu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      full,
	output logic      empty
);

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_CW-1:0] count_q;

	assign full  = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue read while empty");

endmodule

`default_nettype wire

/* rtl/core/jsu_back.sv */
// jsu_back: expands one queued command into its result items, one per cycle while out.ready is high
// depends on jsu_pkg and jsu_out_if
`default_nettype none

module jsu_back
	import jsu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t head,
	input  wire logic empty,
	output logic      pop,
	jsu_out_if.source out
);

	logic [2:0] idx_q;
	logic [2:0] n0, n1, n01, total;
	logic       nt;
	logic [7:0] res_byte;
	logic [1:0] res_kind;
	logic       res_last;
	logic       load;
	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic [1:0] okind_q;
	logic       olast_q;

	assign n0    = head.enc0_en ? utf8_len(head.enc0_cp) : 3'd0;
	assign n1    = head.enc1_en ? utf8_len({5'b00000, head.enc1_cp}) : 3'd0;
	assign nt    = (head.tail != TAIL_NONE);
	assign n01   = n0 + n1;
	assign total = n01 + {2'b00, nt};

	always_comb begin
		res_byte = 8'h00;
		res_kind = KIND_BYTE;
		priority if (idx_q < n0) begin
			res_byte = utf8_byte(head.enc0_cp, n0, idx_q);
		end else if (idx_q < n01) begin
			res_byte = utf8_byte({5'b00000, head.enc1_cp}, n1, idx_q - n0);
		end else begin
			unique case (head.tail)
				TAIL_BYTE: res_byte = head.tail_byte;
				TAIL_END:  res_kind = KIND_END;
				TAIL_ERR:  res_kind = KIND_ERR;
				default:   res_kind = KIND_BYTE;
			endcase
		end
	end

	assign res_last = (idx_q == total - 3'd1);
	assign load     = !empty && (!ovalid_q || out.ready);
	assign pop      = load && res_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				idx_q    <= res_last ? 3'd0 : idx_q + 3'd1;
			end else if (out.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q <= res_byte;
			okind_q <= res_kind;
			olast_q <= res_last;
		end
	end

	assign out.valid    = ovalid_q;
	assign out.out_byte = obyte_q;
	assign out.kind     = okind_q;
	assign out.last     = olast_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (idx_q < total))
		else $error("result index past end of command");

	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 3'd0))
		else $error("result index not cleared after last result");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out.valid)
		else $error("loaded result not presented");

endmodule

`default_nettype wire

/* rtl/core/json_string_unescape_utf8.sv */
// json_string_unescape_utf8: top level of the json string unescaper with utf-8 output
// depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_cmd_fifo, jsu_back
//
// usage:
//   in  carries the raw bytes of quoted json text, one byte per request
//   out carries results: out_byte with kind 0 (decoded byte), kind 1 (string
//   complete) or kind 2 (malformed string); last marks the final result that
//   one input byte causes. after kind 2 the consumer drops that string.
//   an input byte gives zero to six results; bytes that give none (backslash,
//   hex digits, opening quote) are taken without touching the output side.
//   the first result of a byte passes through the command queue and then the
//   output register before out.valid rises. throughput: one result per cycle
//   on out while out.ready is high, one byte per cycle on in while each byte
//   gives at most one result. a \u escape or surrogate pair gives up to six
//   results at one per cycle through the output register; the four-entry
//   command queue absorbs them and in.ready drops only when it fills.
//   a stall on out holds the output register and fills the queue; the parser
//   keeps taking bytes until the queue is full.
//   reset: queue and output empty, parser waits for an opening quote.
`default_nettype none

module json_string_unescape_utf8
	import jsu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	jsu_in_if.sink    in,
	jsu_out_if.source out
);

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic push, pop, full, empty;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in),
		.fifo_full (full),
		.push      (push),
		.cmd       (front_cmd)
	);

	jsu_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.pop    (pop),
		.rdata  (head_cmd),
		.full   (full),
		.empty  (empty)
	);

	jsu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_cmd),
		.empty  (empty),
		.pop    (pop),
		.out    (out)
	);

endmodule

`default_nettype wire
